// ===== rtl/sclc_pkg.sv =====
package sclc_pkg;

  // ring geometry and field widths
  localparam int HIST_DEPTH = 8;
  localparam int LEVEL_W    = 20;
  localparam int SUM_W      = $clog2(HIST_DEPTH * ((2 ** LEVEL_W) - 1) + 1);
  localparam int SLOT_W     = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
  localparam int CFG_IDX_W  = 1;

  // threshold reset values
  localparam logic [LEVEL_W-1:0] PEAK_THR_RST   = LEVEL_W'(4096);
  localparam logic [LEVEL_W-1:0] CHANGE_THR_RST = LEVEL_W'(1024);

  typedef enum logic [1:0] {
    EVT_STEADY = 2'd0,
    EVT_RISE   = 2'd1,
    EVT_FALL   = 2'd2,
    EVT_PEAK   = 2'd3
  } sound_event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PEAK_THR   = 1'b0,
    REG_CHANGE_THR = 1'b1
  } cfg_reg_t;

  // threshold register set
  typedef struct packed {
    logic [LEVEL_W-1:0] peak_thr;
    logic [LEVEL_W-1:0] change_thr;
  } thr_cfg_t;

  // ring memory write request
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    logic [LEVEL_W-1:0] data;
  } ring_wr_t;

endpackage

// ===== rtl/sclc_stream_if.sv =====
interface sclc_level_if;
  logic                        valid;
  logic                        ready;
  logic [sclc_pkg::LEVEL_W-1:0] level_sq;
  logic [sclc_pkg::LEVEL_W-1:0] peak_sq;

  modport source (output valid, output level_sq, output peak_sq, input ready);
  modport sink   (input valid, input level_sq, input peak_sq, output ready);
endinterface

interface sclc_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] sound_event;

  modport source (output valid, output sound_event, input ready);
  modport sink   (input valid, input sound_event, output ready);
endinterface

// ===== rtl/sclc_ring_mem.sv =====
module sclc_ring_mem (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [sclc_pkg::SLOT_W-1:0]   rd_addr,
  output logic [sclc_pkg::LEVEL_W-1:0]  rd_data,
  input  sclc_pkg::ring_wr_t            wr
);

  logic [sclc_pkg::LEVEL_W-1:0] mem [sclc_pkg::HIST_DEPTH];
  logic [sclc_pkg::HIST_DEPTH-1:0] entry_vld;
  logic [sclc_pkg::LEVEL_W-1:0] rd_raw;
  logic                         rd_vld;

  // storage write
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // per-entry written flags, cleared at reset so the ring reads as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
    end else if (wr.en) begin
      entry_vld[wr.addr] <= 1'b1;
    end
  end

  // registered read, write data bypassed on a same-entry collision
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.en && (wr.addr == rd_addr)) begin
        rd_raw <= wr.data;
        rd_vld <= 1'b1;
      end else begin
        rd_raw <= mem[rd_addr];
        rd_vld <= entry_vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_raw : '0;

endmodule

// ===== rtl/sclc_classify.sv =====
module sclc_classify (
  input  logic [sclc_pkg::LEVEL_W-1:0] level,
  input  logic [sclc_pkg::LEVEL_W-1:0] peak,
  input  logic [sclc_pkg::LEVEL_W-1:0] mean,
  input  sclc_pkg::thr_cfg_t           thr,
  output sclc_pkg::sound_event_t       evt
);

  logic [sclc_pkg::LEVEL_W-1:0] peak_diff;
  logic [sclc_pkg::LEVEL_W-1:0] rise_diff;
  logic [sclc_pkg::LEVEL_W-1:0] fall_diff;
  logic                         is_peak;
  logic                         is_rise;
  logic                         is_fall;

  // differences only used when the minuend is larger, so no wrap matters
  assign peak_diff = peak - level;
  assign rise_diff = level - mean;
  assign fall_diff = mean - level;

  assign is_peak = (peak > level) && (peak_diff > thr.peak_thr);
  assign is_rise = (level > mean) && (rise_diff > thr.change_thr);
  assign is_fall = (mean > level) && (fall_diff > thr.change_thr);

  // priority: peak, rise, fall, steady
  always_comb begin
    if (is_peak) begin
      evt = sclc_pkg::EVT_PEAK;
    end else if (is_rise) begin
      evt = sclc_pkg::EVT_RISE;
    end else if (is_fall) begin
      evt = sclc_pkg::EVT_FALL;
    end else begin
      evt = sclc_pkg::EVT_STEADY;
    end
  end

endmodule

// ===== rtl/sound_level_change_classifier_unit.sv =====
// path: an accepted level transaction is registered in stage 1, then its result in the output
// register; throughput: one transaction per cycle while event_out is ready, set by the single
// read-modify-write of the history ring (read on accept, write-back when stage 1 fires)
// reset: ring reads as all zero, running sum and write slot cleared, thresholds
// back to 4096 (peak) and 1024 (change); no clearing pass is needed
module sound_level_change_classifier_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [sclc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sclc_pkg::LEVEL_W-1:0]    cfg_data,
  sclc_level_if.sink                      level_in,
  sclc_event_if.source                    event_out
);

  sclc_pkg::thr_cfg_t           thr;
  logic [sclc_pkg::SLOT_W-1:0]  write_slot;
  logic [sclc_pkg::SUM_W-1:0]   hist_sum;
  logic [sclc_pkg::SUM_W-1:0]   hist_sum_next;

  logic                         s1_valid;
  logic [sclc_pkg::LEVEL_W-1:0] s1_level;
  logic [sclc_pkg::LEVEL_W-1:0] s1_peak;
  logic [sclc_pkg::SLOT_W-1:0]  s1_slot;
  logic                         s1_ready;
  logic                         s1_fire;
  logic                         in_fire;

  logic [sclc_pkg::LEVEL_W-1:0] old_level;
  logic [sclc_pkg::LEVEL_W-1:0] mean;
  sclc_pkg::sound_event_t       evt;
  sclc_pkg::ring_wr_t           ring_wr;

  logic                         out_valid;
  logic [1:0]                   out_event;

  // threshold registers
  always_ff @(posedge clk) begin
    if (rst) begin
      thr.peak_thr   <= sclc_pkg::PEAK_THR_RST;
      thr.change_thr <= sclc_pkg::CHANGE_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sclc_pkg::REG_PEAK_THR:   thr.peak_thr   <= cfg_data;
        sclc_pkg::REG_CHANGE_THR: thr.change_thr <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake
  assign s1_ready        = !out_valid || event_out.ready;
  assign s1_fire         = s1_valid && s1_ready;
  assign level_in.ready  = !s1_valid || s1_ready;
  assign in_fire         = level_in.valid && level_in.ready;

  // write slot advances per accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
    end else if (in_fire) begin
      if (write_slot == sclc_pkg::SLOT_W'(sclc_pkg::HIST_DEPTH - 1)) begin
        write_slot <= '0;
      end else begin
        write_slot <= write_slot + sclc_pkg::SLOT_W'(1);
      end
    end
  end

  // stage 1 holds the transaction while the oldest level is read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (level_in.ready) begin
      s1_valid <= level_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_level <= level_in.level_sq;
      s1_peak  <= level_in.peak_sq;
      s1_slot  <= write_slot;
    end
  end

  // history ring
  assign ring_wr.en   = s1_fire;
  assign ring_wr.addr = s1_slot;
  assign ring_wr.data = s1_level;

  sclc_ring_mem u_ring (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire),
    .rd_addr (write_slot),
    .rd_data (old_level),
    .wr      (ring_wr)
  );

  // mean before update, then running sum swap of oldest for newest
  assign mean          = sclc_pkg::LEVEL_W'(hist_sum / sclc_pkg::HIST_DEPTH);
  assign hist_sum_next = hist_sum - sclc_pkg::SUM_W'(old_level)
                         + sclc_pkg::SUM_W'(s1_level);

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_sum <= '0;
    end else if (s1_fire) begin
      hist_sum <= hist_sum_next;
    end
  end

  sclc_classify u_classify (
    .level (s1_level),
    .peak  (s1_peak),
    .mean  (mean),
    .thr   (thr),
    .evt   (evt)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (event_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_event <= evt;
    end
  end

  assign event_out.valid       = out_valid;
  assign event_out.sound_event = out_event;

  // checks
  a_accept_to_s1: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> s1_valid)
    else $error("accepted transaction did not reach stage 1");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_ready) |=> (s1_valid && $stable(s1_level) && $stable(s1_slot)))
    else $error("stalled stage 1 lost its transaction");

  a_s1_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> out_valid)
    else $error("stage 1 result not presented");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    write_slot <= sclc_pkg::SLOT_W'(sclc_pkg::HIST_DEPTH - 1))
    else $error("write slot out of ring range");

endmodule
